FILE: rtl/cau_pkg.sv
// shared operation codes, status codes and default widths for the complex arithmetic unit
package cau_pkg;

    // default data format
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: pipelined add, subtract, multiply, divide and magnitude on signed
// fixed-point operands. A request enters every cycle the output is not stalled; results leave
// in request order. The pipeline depth is set by the divider and square-root lanes, which
// resolve one quotient or root bit per pipeline stage, DATA_WIDTH stages in all, after three
// stages of product, sum and magnitude preparation. Results are truncated toward zero and
// saturated; status reports saturation or a zero divisor (which returns zero). A stall on the
// result side holds the whole pipeline and stalls the request side in the same cycle.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [2:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] x_re,
    input  logic signed [DATA_WIDTH-1:0] x_im,
    input  logic signed [DATA_WIDTH-1:0] y_re,
    input  logic signed [DATA_WIDTH-1:0] y_im,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic [1:0]                   status
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int RW = 3 * W + FRAC_BITS + 1;
    localparam logic [RW-1:0] LIM = RW'(1) << (W - 1);

    // saturate a sign/magnitude value, returns {flag, value}
    function automatic logic [W:0] sat_fn(input logic neg, input logic [RW-1:0] mag);
        logic [W-1:0] v;
        logic         f;
        f = 1'b0;
        if (!neg) begin
            if (mag > LIM - RW'(1)) begin
                f = 1'b1;
                v = W'(LIM - RW'(1));
            end
            else begin
                v = W'(mag);
            end
        end
        else begin
            if (mag > LIM) begin
                f = 1'b1;
                v = W'(LIM);
            end
            else begin
                v = W'(RW'(0) - mag);
            end
        end
        return {f, v};
    endfunction

    logic en;

    // global advance: hold everything while a result waits
    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    // ---------------- stage 1: products and add/subtract ----------------
    logic                 vld1_reg;
    logic [2:0]           op1_reg;
    logic [W:0]           as_re_next, as_im_next;
    logic [W:0]           as_re_reg, as_im_reg;
    logic signed [PW-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg, aa_reg, bb_reg;
    logic signed [W:0]    s_re, s_im;
    logic [W:0]           m_re, m_im;

    // add or subtract, then saturate
    always_comb
    begin
        if (req_type == OP_SUB) begin
            s_re = (W+1)'(x_re) - (W+1)'(y_re);
            s_im = (W+1)'(x_im) - (W+1)'(y_im);
        end
        else begin
            s_re = (W+1)'(x_re) + (W+1)'(y_re);
            s_im = (W+1)'(x_im) + (W+1)'(y_im);
        end
        m_re       = s_re[W] ? (W+1)'(-s_re) : (W+1)'(s_re);
        m_im       = s_im[W] ? (W+1)'(-s_im) : (W+1)'(s_im);
        as_re_next = sat_fn(s_re[W], RW'(m_re));
        as_im_next = sat_fn(s_im[W], RW'(m_im));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld1_reg <= 1'b0;
        end
        else if (en) begin
            vld1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            op1_reg   <= req_type;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
            ac_reg    <= x_re * y_re;
            bd_reg    <= x_im * y_im;
            ad_reg    <= x_re * y_im;
            bc_reg    <= x_im * y_re;
            cc_reg    <= y_re * y_re;
            dd_reg    <= y_im * y_im;
            aa_reg    <= x_re * x_re;
            bb_reg    <= x_im * x_im;
        end
    end

    // ---------------- stage 2: sums of products ----------------
    logic                 vld2_reg;
    logic [2:0]           op2_reg;
    logic [W:0]           as2_re_reg, as2_im_reg;
    logic signed [PW:0]   mre_reg, mim_reg, nre_reg, nim_reg;
    logic [PW-1:0]        den2_reg, sq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld2_reg <= 1'b0;
        end
        else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            op2_reg    <= op1_reg;
            as2_re_reg <= as_re_reg;
            as2_im_reg <= as_im_reg;
            mre_reg    <= (PW+1)'(ac_reg) - (PW+1)'(bd_reg);
            mim_reg    <= (PW+1)'(ad_reg) + (PW+1)'(bc_reg);
            nre_reg    <= (PW+1)'(ac_reg) + (PW+1)'(bd_reg);
            nim_reg    <= (PW+1)'(bc_reg) - (PW+1)'(ad_reg);
            den2_reg   <= PW'($unsigned(cc_reg)) + PW'($unsigned(dd_reg));
            sq2_reg    <= PW'($unsigned(aa_reg)) + PW'($unsigned(bb_reg));
        end
    end

    // ---------------- stage 3: multiply result, divide operands ----------------
    logic            vld_reg   [0:W];
    logic [2:0]      op_reg    [0:W];
    logic [W:0]      fre_reg   [0:W];
    logic [W:0]      fim_reg   [0:W];
    logic            sgr_reg   [0:W];
    logic            sgi_reg   [0:W];
    logic            divz_reg  [0:W];
    logic            ovr_reg   [0:W];
    logic            ovi_reg   [0:W];
    logic [RW-1:0]   rr_reg    [0:W];
    logic [RW-1:0]   ri_reg    [0:W];
    logic [W-1:0]    qr_reg    [0:W];
    logic [W-1:0]    qi_reg    [0:W];
    logic [PW-1:0]   den_reg   [0:W];
    logic [PW-1:0]   sqs_reg   [0:W];
    logic [PW-1:0]   root_reg  [0:W];

    logic [PW:0]     mre_mag, mim_mag, nre_mag, nim_mag;
    logic [W:0]      fre_next, fim_next;

    // truncate and saturate the product, take divide magnitudes
    always_comb
    begin
        mre_mag = mre_reg[PW] ? (PW+1)'(-mre_reg) : (PW+1)'(mre_reg);
        mim_mag = mim_reg[PW] ? (PW+1)'(-mim_reg) : (PW+1)'(mim_reg);
        nre_mag = nre_reg[PW] ? (PW+1)'(-nre_reg) : (PW+1)'(nre_reg);
        nim_mag = nim_reg[PW] ? (PW+1)'(-nim_reg) : (PW+1)'(nim_reg);
        if (op2_reg == OP_MUL) begin
            fre_next = sat_fn(mre_reg[PW], RW'(mre_mag >> FRAC_BITS));
            fim_next = sat_fn(mim_reg[PW], RW'(mim_mag >> FRAC_BITS));
        end
        else begin
            fre_next = as2_re_reg;
            fim_next = as2_im_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end
        else if (en) begin
            vld_reg[0] <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            op_reg[0]   <= op2_reg;
            fre_reg[0]  <= fre_next;
            fim_reg[0]  <= fim_next;
            sgr_reg[0]  <= nre_reg[PW];
            sgi_reg[0]  <= nim_reg[PW];
            divz_reg[0] <= (den2_reg == '0);
            ovr_reg[0]  <= 1'b0;
            ovi_reg[0]  <= 1'b0;
            rr_reg[0]   <= RW'(nre_mag) << FRAC_BITS;
            ri_reg[0]   <= RW'(nim_mag) << FRAC_BITS;
            qr_reg[0]   <= '0;
            qi_reg[0]   <= '0;
            den_reg[0]  <= den2_reg;
            sqs_reg[0]  <= sq2_reg;
            root_reg[0] <= '0;
        end
    end

    // ---------------- divide and square-root stages, one bit each ----------------
    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_step
            localparam int I = W - 1 - k;
            logic [RW-1:0] dsh;
            logic [RW-1:0] rr_next, ri_next;
            logic [W-1:0]  qr_next, qi_next;
            logic          ovr_next, ovi_next;
            logic [PW-1:0] bitv;
            logic [PW:0]   trial;
            logic [PW-1:0] sqs_next, root_next;

            // restoring divide step for both parts, plus overflow check up front
            always_comb
            begin
                dsh     = RW'(den_reg[k]) << I;
                rr_next = rr_reg[k];
                ri_next = ri_reg[k];
                qr_next = qr_reg[k];
                qi_next = qi_reg[k];
                if (rr_reg[k] >= dsh) begin
                    rr_next = rr_reg[k] - dsh;
                    qr_next = qr_reg[k] | (W'(1) << I);
                end
                if (ri_reg[k] >= dsh) begin
                    ri_next = ri_reg[k] - dsh;
                    qi_next = qi_reg[k] | (W'(1) << I);
                end
                if (k == 0) begin
                    ovr_next = (rr_reg[k] >= (RW'(den_reg[k]) << W));
                    ovi_next = (ri_reg[k] >= (RW'(den_reg[k]) << W));
                end
                else begin
                    ovr_next = ovr_reg[k];
                    ovi_next = ovi_reg[k];
                end
            end

            // square-root step
            always_comb
            begin
                bitv  = PW'(1) << (2 * I);
                trial = (PW+1)'(root_reg[k]) + (PW+1)'(bitv);
                if ((PW+1)'(sqs_reg[k]) >= trial) begin
                    sqs_next  = PW'((PW+1)'(sqs_reg[k]) - trial);
                    root_next = (root_reg[k] >> 1) + bitv;
                end
                else begin
                    sqs_next  = sqs_reg[k];
                    root_next = root_reg[k] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (en) begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en) begin
                    op_reg[k+1]   <= op_reg[k];
                    fre_reg[k+1]  <= fre_reg[k];
                    fim_reg[k+1]  <= fim_reg[k];
                    sgr_reg[k+1]  <= sgr_reg[k];
                    sgi_reg[k+1]  <= sgi_reg[k];
                    divz_reg[k+1] <= divz_reg[k];
                    ovr_reg[k+1]  <= ovr_next;
                    ovi_reg[k+1]  <= ovi_next;
                    rr_reg[k+1]   <= rr_next;
                    ri_reg[k+1]   <= ri_next;
                    qr_reg[k+1]   <= qr_next;
                    qi_reg[k+1]   <= qi_next;
                    den_reg[k+1]  <= den_reg[k];
                    sqs_reg[k+1]  <= sqs_next;
                    root_reg[k+1] <= root_next;
                end
            end
        end
    endgenerate

    // ---------------- final stage: select, saturate, status ----------------
    logic             res_valid_reg;
    logic [W-1:0]     res_re_reg, res_re_next;
    logic [W-1:0]     res_im_reg, res_im_next;
    logic [1:0]       status_reg, status_next;
    logic [W:0]       dre, dim, mg;

    always_comb
    begin
        dre = sat_fn(sgr_reg[W], ovr_reg[W] ? '1 : RW'(qr_reg[W]));
        dim = sat_fn(sgi_reg[W], ovi_reg[W] ? '1 : RW'(qi_reg[W]));
        mg  = sat_fn(1'b0, RW'(root_reg[W]));
        res_re_next = '0;
        res_im_next = '0;
        status_next = ST_OK;
        case (op_reg[W])
            OP_ADD, OP_SUB, OP_MUL: begin
                res_re_next = fre_reg[W][W-1:0];
                res_im_next = fim_reg[W][W-1:0];
                status_next = (fre_reg[W][W] || fim_reg[W][W]) ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (divz_reg[W]) begin
                    status_next = ST_DIVZ;
                end
                else begin
                    res_re_next = dre[W-1:0];
                    res_im_next = dim[W-1:0];
                    status_next = (dre[W] || dim[W]) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                res_re_next = mg[W-1:0];
                status_next = mg[W] ? ST_SAT : ST_OK;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (en) begin
            res_valid_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign status    = status_reg;

    // ---------------- assertions ----------------
    // no undefined status code reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status != 2'd3))
        else $error("undefined status code");

    // a zero divisor always returns zero parts
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status == ST_DIVZ) |-> (res_re == '0 && res_im == '0))
        else $error("divide by zero result not zero");

    // magnitude leaves a nonnegative real part and a zero imaginary part
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[W] && op_reg[W] == OP_MAG) |=> (res_im == '0 && !res_re[W-1]))
        else $error("magnitude result malformed");

endmodule
